FILE: rtl/core/gtp_pkg.sv
package gtp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN = 24;
  localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int NORM = 6;
  localparam int VW = 46;
  localparam int ZW = 32;
  localparam int IW = $clog2(TABLE_LEN);

  localparam logic signed [ZW:0] PI28 = 33'sd843314857;
  localparam logic signed [ZW:0] TWO_PI28 = 33'sd1686629713;
  localparam logic signed [34:0] RATE_MAX = 35'sd8388607;
  localparam logic signed [34:0] RATE_MIN = -35'sd8388608;

  typedef enum logic [2:0] {
    REG_GOAL_X      = 3'd0,
    REG_GOAL_Y      = 3'd1,
    REG_GAIN        = 3'd2,
    REG_STOP_RADIUS = 3'd3,
    REG_SLOW_RADIUS = 3'd4,
    REG_FAST_SPEED  = 3'd5,
    REG_SLOW_SPEED  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic far_stop;
    logic far_slow;
  } dist_t;

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return (v < 0) ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic signed [ZW-1:0] atan_q28(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 32'sd210828714;
      5'd1:  r = 32'sd124459457;
      5'd2:  r = 32'sd65760959;
      5'd3:  r = 32'sd33381290;
      5'd4:  r = 32'sd16755422;
      5'd5:  r = 32'sd8385879;
      5'd6:  r = 32'sd4193963;
      5'd7:  r = 32'sd2097109;
      5'd8:  r = 32'sd1048571;
      5'd9:  r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/gtp_if.sv
interface gtp_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface gtp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] angular_rate;
  logic        [15:0] linear_speed;
  modport source (output valid, angular_rate, linear_speed, input ready);
  modport sink (input valid, angular_rate, linear_speed, output ready);
endinterface

FILE: rtl/core/gtp_norm_cell.sv
module gtp_norm_cell import gtp_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [5:0] k,
  input  vec_t       d,
  output vec_t       q
);

  logic [VW-1:0] ax, ay, m, lim;
  vec_t nxt;

  // shift left by k while the larger magnitude stays below 2^41
  always_comb begin
    ax = mag(d.x);
    ay = mag(d.y);
    m = (ax > ay) ? ax : ay;
    lim = VW'(1) << (6'd41 - k);
    nxt = d;
    if (m < lim) begin
      nxt.x = d.x <<< k;
      nxt.y = d.y <<< k;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

FILE: rtl/core/gtp_cordic_cell.sv
module gtp_cordic_cell import gtp_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] idx,
  input  vec_t          d,
  output vec_t          q
);

  logic signed [VW-1:0] xs, ys;
  vec_t nxt;

  always_comb begin
    xs = d.x >>> idx;
    ys = d.y >>> idx;
    nxt = d;
    if (d.y > 0) begin
      nxt.x = d.x + ys;
      nxt.y = d.y - xs;
      nxt.z = d.z + atan_q28(idx);
    end else begin
      nxt.x = d.x - ys;
      nxt.y = d.y + xs;
      nxt.z = d.z - atan_q28(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

FILE: rtl/core/go_to_point_steering.sv
// proportional go-to-goal steering
// pose channel (sink): position Q16.16 and orientation quaternion Q1.15
// cmd channel (source): angular_rate Q.13 and linear_speed Q8.8, one per pose
// config: write cfg_data to register cfg_index when cfg_we is high, only
//   while no request is in flight; unknown indexes are ignored
// heading and bearing each run through two rows of cells: six normalize
//   cells and one CORDIC cell per stage (16 by default), side by side
// path from pose accept to cmd valid: front registers, normalize cells,
//   pre-rotation register, CORDIC cells, error register, output register
// throughput: one pose per cycle unless cmd stalls; the row advances together
// when cmd is stalled the row holds and pose.ready drops in the same cycle;
//   with cmd.valid low the block always takes a pose
// reset: synchronous, clears all valid bits and restores the default
//   goal, gain, radii and speeds; no clearing pass is needed
module go_to_point_steering import gtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gtp_pose_if.sink    pose,
  gtp_cmd_if.source   cmd,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LAT = 9 + NSTG;
  localparam int FL = LAT - 2;

  logic signed [31:0] goal_x, goal_y;
  logic [15:0] gain, fast_speed, slow_speed;
  logic [30:0] stop_radius, slow_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= 32'sd262144;
      goal_y <= 32'sd98304;
      gain <= 16'd256;
      stop_radius <= 31'd6554;
      slow_radius <= 31'd32768;
      fast_speed <= 16'd256;
      slow_speed <= 16'd77;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:      goal_x <= cfg_data;
        REG_GOAL_Y:      goal_y <= cfg_data;
        REG_GAIN:        gain <= cfg_data[15:0];
        REG_STOP_RADIUS: stop_radius <= cfg_data[30:0];
        REG_SLOW_RADIUS: slow_radius <= cfg_data[30:0];
        REG_FAST_SPEED:  fast_speed <= cfg_data[15:0];
        REG_SLOW_SPEED:  slow_speed <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !cmd.valid || cmd.ready;
  assign pose.ready = en;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], pose.valid};
  end

  // front stage: differences and quaternion products
  logic signed [32:0] dx_c, dy_c, dx, dy;
  logic signed [33:0] num_c, den_c;
  vec_t nrm_yaw [NORM+1];
  vec_t nrm_brg [NORM+1];

  always_comb begin
    dx_c = 33'(goal_x) - 33'(pose.pos_x);
    dy_c = 33'(goal_y) - 33'(pose.pos_y);
    num_c = 34'(pose.quat_w * pose.quat_z) + 34'(pose.quat_x * pose.quat_y);
    num_c = num_c <<< 1;
    den_c = 34'(pose.quat_w * pose.quat_w) + 34'(pose.quat_x * pose.quat_x)
          - 34'(pose.quat_y * pose.quat_y) - 34'(pose.quat_z * pose.quat_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= dx_c;
      dy <= dy_c;
      nrm_yaw[0].x <= VW'(den_c);
      nrm_yaw[0].y <= VW'(num_c);
      nrm_yaw[0].z <= '0;
      nrm_yaw[0].zero <= (den_c == 0) && (num_c == 0);
      nrm_brg[0].x <= VW'(dx_c);
      nrm_brg[0].y <= VW'(dy_c);
      nrm_brg[0].z <= '0;
      nrm_brg[0].zero <= (dx_c == 0) && (dy_c == 0);
    end
  end

  // distance checks against squared radii
  logic [31:0] ax, ay;
  logic [63:0] sq_x, sq_y;
  logic [61:0] rs2, rl2;
  logic [64:0] sum;
  dist_t dist_c;
  dist_t fl [FL];

  always_comb begin
    ax = (dx < 0) ? 32'(-dx) : 32'(dx);
    ay = (dy < 0) ? 32'(-dy) : 32'(dy);
    sum = 65'(sq_x) + 65'(sq_y);
    dist_c.far_stop = sum > 65'(rs2);
    dist_c.far_slow = sum > 65'(rl2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= ax * ax;
      sq_y <= ay * ay;
      rs2 <= stop_radius * stop_radius;
      rl2 <= slow_radius * slow_radius;
      fl[0] <= dist_c;
      for (int i = 1; i < FL; i++) fl[i] <= fl[i-1];
    end
  end

  // normalize rows: shifts of 32, 16, 8, 4, 2, 1
  for (genvar j = 0; j < NORM; j++) begin : g_norm
    gtp_norm_cell u_yaw (
      .clk(clk), .en(en), .k(6'(1 << (NORM - 1 - j))),
      .d(nrm_yaw[j]), .q(nrm_yaw[j+1])
    );
    gtp_norm_cell u_brg (
      .clk(clk), .en(en), .k(6'(1 << (NORM - 1 - j))),
      .d(nrm_brg[j]), .q(nrm_brg[j+1])
    );
  end

  // left half plane: rotate by pi toward the right half
  function automatic vec_t prerot(input vec_t v);
    vec_t r;
    r = v;
    if (v.x < 0) begin
      r.z = (v.y >= 0) ? ZW'(PI28) : ZW'(-PI28);
      r.x = -v.x;
      r.y = -v.y;
    end
    return r;
  endfunction

  vec_t cor_yaw [NSTG+1];
  vec_t cor_brg [NSTG+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cor_yaw[0] <= prerot(nrm_yaw[NORM]);
      cor_brg[0] <= prerot(nrm_brg[NORM]);
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    gtp_cordic_cell u_yaw (
      .clk(clk), .en(en), .idx(IW'(i)), .d(cor_yaw[i]), .q(cor_yaw[i+1])
    );
    gtp_cordic_cell u_brg (
      .clk(clk), .en(en), .idx(IW'(i)), .d(cor_brg[i]), .q(cor_brg[i+1])
    );
  end

  // heading error, wrapped and rounded to Q3.13
  logic signed [ZW:0] yaw, brg, err;
  logic signed [ZW+1:0] err_w;
  logic signed [16:0] err13_c, err13;

  always_comb begin
    yaw = cor_yaw[NSTG].zero ? '0 : (ZW+1)'(cor_yaw[NSTG].z);
    brg = cor_brg[NSTG].zero ? '0 : (ZW+1)'(cor_brg[NSTG].z);
    err = brg - yaw;
    if (err > PI28) err = err - TWO_PI28;
    else if (err < -PI28) err = err + TWO_PI28;
    err_w = (ZW+2)'(err) + 34'sd16384;
    err13_c = 17'(err_w >>> 15);
  end

  always_ff @(posedge clk) begin
    if (en) err13 <= err13_c;
  end

  logic signed [33:0] prod;
  logic signed [34:0] rate;
  logic signed [23:0] rate_sat;

  always_comb begin
    prod = $signed({1'b0, gain}) * err13;
    rate = (35'(prod) + 35'sd128) >>> 8;
    if (rate > RATE_MAX) rate_sat = 24'sh7FFFFF;
    else if (rate < RATE_MIN) rate_sat = -24'sh800000;
    else rate_sat = 24'(rate);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (en) begin
      cmd.valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[FL-1].far_stop) begin
        cmd.angular_rate <= rate_sat;
        cmd.linear_speed <= fl[FL-1].far_slow ? fast_speed : slow_speed;
      end else begin
        cmd.angular_rate <= '0;
        cmd.linear_speed <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/gtp_checker.sv
module gtp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] angular_rate,
  input logic        [15:0] linear_speed
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angular_rate) && $stable(linear_speed))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // the row stalls as a whole when the result is held back
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("pose taken while row is stalled");

  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pose refused with empty output");

endmodule

bind go_to_point_steering gtp_checker u_chk (
  .clk(clk),
  .rst(rst),
  .in_ready(pose.ready),
  .out_valid(cmd.valid),
  .out_ready(cmd.ready),
  .angular_rate(cmd.angular_rate),
  .linear_speed(cmd.linear_speed)
);

FILE: verif/go_to_point_steering_test.sv
module go_to_point_steering_test;
  import gtp_pkg::*;

  localparam int LATENCY = 10 + NSTG;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint PI_Q28 = 843314857;
  localparam longint TWO_PI_Q28 = 1686629713;

  typedef struct {
    logic signed [23:0] angular_rate;
    logic [15:0]        linear_speed;
  } steer_cmd_t;

  // steering command predictor with its own copy of the registers
  class steer_board;
    longint signed goal_x, goal_y;
    longint unsigned gain, stop_radius, slow_radius, fast_speed, slow_speed;
    steer_cmd_t pending[$];
    int errors;
    int checked;

    function new();
      goal_x = 262144;
      goal_y = 98304;
      gain = 256;
      stop_radius = 6554;
      slow_radius = 32768;
      fast_speed = 256;
      slow_speed = 77;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_GOAL_X: goal_x = longint'($signed(data));
        REG_GOAL_Y: goal_y = longint'($signed(data));
        REG_GAIN: gain = data[15:0];
        REG_STOP_RADIUS: stop_radius = data[30:0];
        REG_SLOW_RADIUS: slow_radius = data[30:0];
        REG_FAST_SPEED: fast_speed = data[15:0];
        REG_SLOW_SPEED: slow_speed = data[15:0];
        default: ;
      endcase
    endfunction

    // arithmetic shift rounding toward minus infinity
    function longint signed floor_shift(longint signed v, int s);
      return v >>> s;
    endfunction

    function longint signed heading_q28(longint signed y, longint signed x);
      longint signed z, m, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
      while (m < (64'sd1 << 40)) begin
        x = x * 2;
        y = y * 2;
        m = m * 2;
      end
      if (x < 0) begin
        z = (y >= 0) ? PI_Q28 : -PI_Q28;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < NSTG; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(atan_q28(IW'(i)));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(atan_q28(IW'(i)));
        end
      end
      return z;
    endfunction

    // exact dx^2 + dy^2 > r^2 with 64-bit wrap meaning overflow
    function bit beyond(longint unsigned ax, longint unsigned ay, longint unsigned r);
      longint unsigned s, t, sum;
      s = ax * ax;
      t = ay * ay;
      sum = s + t;
      if (sum < s) return 1;
      return sum > r * r;
    endfunction

    function void note_pose(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz);
      longint signed dx, dy, num, den, err, err13, rate;
      longint unsigned ax, ay;
      steer_cmd_t c;
      dx = goal_x - longint'(px);
      dy = goal_y - longint'(py);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (!beyond(ax, ay, stop_radius)) begin
        c.angular_rate = '0;
        c.linear_speed = '0;
      end else begin
        num = 2 * (longint'(qw) * qz + longint'(qx) * qy);
        den = longint'(qw) * qw + longint'(qx) * qx - longint'(qy) * qy - longint'(qz) * qz;
        err = heading_q28(dy, dx) - heading_q28(num, den);
        if (err > PI_Q28) err = err - TWO_PI_Q28;
        else if (err < -PI_Q28) err = err + TWO_PI_Q28;
        err13 = floor_shift(err + 16384, 15);
        rate = floor_shift(longint'(gain) * err13 + 128, 8);
        if (rate > 8388607) rate = 8388607;
        if (rate < -8388608) rate = -8388608;
        c.angular_rate = rate[23:0];
        c.linear_speed = beyond(ax, ay, slow_radius) ? fast_speed[15:0] : slow_speed[15:0];
      end
      pending.push_back(c);
    endfunction

    function void check_cmd(logic signed [23:0] rate, logic [15:0] speed);
      steer_cmd_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected command rate=%0d speed=%0d", $time, rate, speed);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rate !== e.angular_rate) begin
        $display("%0t: angular_rate expected %0d actual %0d", $time, e.angular_rate, rate);
        errors++;
      end
      if (speed !== e.linear_speed) begin
        $display("%0t: linear_speed expected %0d actual %0d", $time, e.linear_speed, speed);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int sender_idle_pct;
  int receiver_idle_pct;
  int quiet_cycles;
  int poses_sent;
  steer_board board;

  gtp_pose_if pose ();
  gtp_cmd_if cmd ();

  go_to_point_steering dut (
    .clk(clk),
    .rst(rst),
    .pose(pose.sink),
    .cmd(cmd.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stall, checking, watchdog
  always @(posedge clk) begin
    if (rst) begin
      cmd.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      cmd.ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (cmd.valid && cmd.ready) board.check_cmd(cmd.angular_rate, cmd.linear_speed);
      if ((cmd.valid && cmd.ready) || (pose.valid && pose.ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back requests; idling and drain drop it
  task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [15:0] qw, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      pose.valid <= 1'b0;
      @(posedge clk);
    end
    pose.valid <= 1'b1;
    pose.pos_x <= px;
    pose.pos_y <= py;
    pose.quat_w <= qw;
    pose.quat_x <= qx;
    pose.quat_y <= qy;
    pose.quat_z <= qz;
    do @(posedge clk); while (!pose.ready);
    board.note_pose(px, py, qw, qx, qy, qz);
    poses_sent++;
  endtask

  task automatic drain();
    pose.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // write enable stays up across a burst of writes; the next request drops it
  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic random_pose();
    logic signed [31:0] px, py;
    int mode;
    mode = $urandom_range(3);
    case (mode)
      0: begin  // near the goal, around both radii
        px = board.goal_x[31:0] + $signed(32'($urandom_range(80000)) - 32'sd40000);
        py = board.goal_y[31:0] + $signed(32'($urandom_range(80000)) - 32'sd40000);
      end
      1: begin
        px = board.goal_x[31:0] + $signed(32'($urandom_range(2000000)) - 32'sd1000000);
        py = board.goal_y[31:0] + $signed(32'($urandom_range(2000000)) - 32'sd1000000);
      end
      default: begin
        px = $urandom;
        py = $urandom;
      end
    endcase
    send_pose(px, py, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_regs(bit extreme);
    write_reg(REG_GOAL_X, extreme ? 32'h8000_0000 : $urandom_range(600000) - 300000);
    write_reg(REG_GOAL_Y, extreme ? 32'h7fff_ffff : $urandom_range(600000) - 300000);
    write_reg(REG_GAIN, extreme ? 32'hffff_ffff : $urandom);
    write_reg(REG_STOP_RADIUS, extreme ? 32'hffff_ffff : $urandom_range(20000));
    write_reg(REG_SLOW_RADIUS, extreme ? 32'd0 : $urandom_range(60000));
    write_reg(REG_FAST_SPEED, extreme ? 32'h0001_ffff : $urandom);
    write_reg(REG_SLOW_SPEED, extreme ? 32'd0 : $urandom);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pose.valid = 1'b0;
    pose.pos_x = '0;
    pose.pos_y = '0;
    pose.quat_w = '0;
    pose.quat_x = '0;
    pose.quat_y = '0;
    pose.quat_z = '0;
    sender_idle_pct = 37;
    receiver_idle_pct = 48;
    poses_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: at the goal, zero quaternion, field extremes, wrap cases
    send_pose(32'sd262144, 32'sd98304, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sd0, 32'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sd0, 32'sd0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pose(32'sd0, 32'sd0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_pose(32'sd262144, 32'sd98304 + 32'sd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_pose(32'sd262144 + 32'sd20000, 32'sd98304, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_pose(32'sd262144 + 32'sd6554, 32'sd98304, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sd262144 + 32'sd6555, 32'sd98304, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sd262144 + 32'sd32768, 32'sd98304, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sd262144 + 32'sd32769, 32'sd98304, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    send_pose(32'sh8000_0000, 32'sh8000_0000, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0);
    send_pose(32'sh8000_0000, 32'sd98304, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_pose(32'sh7fff_ffff, 32'sh8000_0000, -16'sd1, 16'sd1, -16'sd1, 16'sd1);
    // the sender holds off until the pipe is empty before reconfiguring
    drain();
    random_regs(1'b1);
    write_reg(REG_GAIN, 32'hffff);
    for (int i = 0; i < 8; i++) random_pose();
    send_pose(32'sh7fff_ffff, 32'sh8000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
    drain();
    // slow radius below stop radius, and extreme goal
    write_reg(REG_GOAL_X, 32'h7fff_ffff);
    write_reg(REG_GOAL_Y, 32'h8000_0000);
    write_reg(REG_STOP_RADIUS, 32'd50000);
    write_reg(REG_SLOW_RADIUS, 32'd100);
    write_reg(REG_GAIN, 32'd0);
    send_pose(32'sh8000_0000, 32'sh7fff_ffff, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_pose(32'sh7fff_ffff, 32'sh8000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        sender_idle_pct = 48;
        receiver_idle_pct = 37;
      end else if (phase == 8) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      random_regs(phase == 11);
      if (phase == 0) begin
        write_reg(REG_GOAL_X, 32'd262144);
        write_reg(REG_GOAL_Y, 32'd98304);
      end
      for (int i = 0; i < 100; i++) random_pose();
      drain();
    end

    $display("steering run: %0d poses, %0d commands checked over directed, random and",
             poses_sent, board.checked);
    $display("register-sweep phases with and without back-pressure");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
